// ===== rtl/core/keyboard_scancode_translator_unit_defines.svh =====
// assertion macros for the keyboard scancode translator
// expects signals named clock and reset in the scope of each use

`ifndef KEYBOARD_SCANCODE_TRANSLATOR_UNIT_DEFINES_SVH
`define KEYBOARD_SCANCODE_TRANSLATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define KST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/kst_pkg.sv =====
// shared constants and codes for the keyboard scancode translator
// no dependencies

`default_nettype none

package kst_pkg;

   // field widths
   localparam int SCANCODE_W = 8;
   localparam int MAP_SEL_W  = 3;
   localparam int MAP_IDX_W  = 7;
   localparam int CHAR_W     = 8;

   // map storage
   localparam int NUM_MAPS            = 8;
   localparam int MAP_ENTRIES_DEFAULT = 128;

   // input operation codes
   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_MAP_WRITE = 1'b1;

   // result kind codes
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_CMD  = 1'b1;

   // scancodes of interest
   localparam logic [SCANCODE_W-1:0] CODE_LIMIT     = 8'h57;
   localparam logic [SCANCODE_W-1:0] CODE_CAPS      = 8'h3A;
   localparam logic [SCANCODE_W-1:0] CODE_RSHIFT    = 8'h36;
   localparam logic [SCANCODE_W-1:0] CODE_LSHIFT    = 8'h2A;
   localparam logic [SCANCODE_W-1:0] CODE_RSHIFT_UP = 8'hB6;
   localparam logic [SCANCODE_W-1:0] CODE_LSHIFT_UP = 8'hAA;
   localparam logic [SCANCODE_W-1:0] CODE_NUM       = 8'h45;

   // keyboard command
   localparam logic [CHAR_W-1:0] CMD_SET_LEDS = 8'hED;

endpackage

`default_nettype wire

// ===== rtl/core/kst_req_if.sv =====
// request channel: scancode bytes and map-entry writes
// depends on kst_pkg

`default_nettype none

interface kst_req_if;
   import kst_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [SCANCODE_W-1:0] scancode;
   logic [MAP_SEL_W-1:0]  map_select;
   logic [MAP_IDX_W-1:0]  map_index;
   logic [CHAR_W-1:0]     map_char;

   modport source (output valid, op, scancode, map_select, map_index, map_char,
                   input ready);
   modport sink   (input valid, op, scancode, map_select, map_index, map_char,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kst_rsp_if.sv =====
// response channel: characters for the host and keyboard command bytes
// depends on kst_pkg

`default_nettype none

interface kst_rsp_if;
   import kst_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [CHAR_W-1:0] value;
   logic              last;

   modport source (output valid, kind, value, last, input ready);
   modport sink   (input valid, kind, value, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kst_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies

`default_nettype none

module kst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/keyboard_scancode_translator_unit.sv =====
// Keyboard scancode translator (set 1). A map-write item stores one character in one of
// eight maps (num*4 + caps*2 + shift); a scancode item updates the shift, caps-lock and
// num-lock flags or looks up a character. Shift codes and map writes give no result, a
// caps-lock or num-lock code gives two keyboard command bytes (0xED, then the LED value
// with scroll lock always lit), other codes below 0x57 give one character, all else is
// dropped. A new item is taken while the lookup stage is empty or being emptied; a held
// result stalls it, and a lock code keeps the stage until both command bytes have left
// through the one result register. The maps hold no reset value, so the block is ready
// right after reset; reading an unwritten entry gives any byte.
// depends on kst_pkg, kst_req_if, kst_rsp_if, kst_ram and the defines header

`default_nettype none

`include "keyboard_scancode_translator_unit_defines.svh"

module keyboard_scancode_translator_unit #(
   parameter int MAP_ENTRIES = kst_pkg::MAP_ENTRIES_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   kst_req_if.sink   req_ch,
   kst_rsp_if.source rsp_ch
);
   import kst_pkg::*;

   localparam int RAM_DEPTH = NUM_MAPS * MAP_ENTRIES;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);

   // flags
   logic shift_held_ff, shift_held_in;
   logic caps_on_ff, caps_on_in;
   logic num_on_ff, num_on_in;

   // lookup stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_led_ff, s1_led_in;
   logic              s1_second_ff, s1_second_in;
   logic [CHAR_W-1:0] s1_leds_ff, s1_leds_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [CHAR_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_ready;
   logic              req_fire;
   logic              is_write, is_shift_up, is_shift_dn, is_caps, is_num, is_char, is_lock;
   logic              out_load, s1_done;
   logic              map_wr_en, map_rd_en;
   logic [ADDR_W-1:0] map_wr_addr, map_rd_addr;
   logic [CHAR_W-1:0] map_rd_data;
   logic [2:0]        read_sel;

   // request decode
   always_comb begin
      is_write    = (req_ch.op == OP_MAP_WRITE);
      is_shift_up = !is_write && ((req_ch.scancode == CODE_RSHIFT_UP) ||
                                  (req_ch.scancode == CODE_LSHIFT_UP));
      is_shift_dn = !is_write && ((req_ch.scancode == CODE_RSHIFT) ||
                                  (req_ch.scancode == CODE_LSHIFT));
      is_caps     = !is_write && (req_ch.scancode == CODE_CAPS);
      is_num      = !is_write && (req_ch.scancode == CODE_NUM);
      is_lock     = is_caps || is_num;
      is_char     = !is_write && (req_ch.scancode < CODE_LIMIT) && !is_shift_dn && !is_lock;
   end

   // pipeline flow control
   assign out_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign s1_done   = out_load && (!s1_led_ff || s1_second_ff);
   assign req_ready = !s1_valid_ff || s1_done;
   assign req_fire  = req_ch.valid && req_ready;

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.kind  = rsp_kind_ff;
   assign rsp_ch.value = rsp_value_ff;
   assign rsp_ch.last  = rsp_last_ff;

   // map addresses: map number times map size plus entry
   assign read_sel    = {num_on_ff, caps_on_ff, shift_held_ff};
   assign map_wr_en   = req_fire && is_write &&
                        (32'(req_ch.map_index) < 32'(MAP_ENTRIES));
   assign map_wr_addr = ADDR_W'(ADDR_W'(req_ch.map_select) * ADDR_W'(MAP_ENTRIES)
                                + ADDR_W'(req_ch.map_index));
   assign map_rd_en   = req_fire && is_char;
   assign map_rd_addr = ADDR_W'(ADDR_W'(read_sel) * ADDR_W'(MAP_ENTRIES)
                                + ADDR_W'(req_ch.scancode[MAP_IDX_W-1:0]));

   kst_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (RAM_DEPTH)
   ) u_maps (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (req_ch.map_char),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // flag updates on each scancode transfer
   always_comb begin
      shift_held_in = shift_held_ff;
      caps_on_in    = caps_on_ff;
      num_on_in     = num_on_ff;
      if (req_fire) begin
         if (is_shift_up) begin
            shift_held_in = 1'b0;
         end else if (is_shift_dn) begin
            shift_held_in = 1'b1;
         end
         if (is_caps) begin
            caps_on_in = !caps_on_ff;
         end
         if (is_num) begin
            num_on_in = !num_on_ff;
         end
      end
   end

   // lookup stage: holds a character lookup or a led command pair
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_led_in    = s1_led_ff;
      s1_second_in = s1_second_ff;
      s1_leds_in   = s1_leds_ff;
      if (req_ready) begin
         s1_valid_in  = req_fire && (is_char || is_lock);
         s1_led_in    = is_lock;
         s1_second_in = 1'b0;
         s1_leds_in   = {5'b00000, caps_on_in, num_on_in, 1'b1};
      end else if (out_load) begin
         s1_second_in = 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         case ({s1_led_ff, s1_second_ff})
            2'b10: begin
               rsp_kind_in  = KIND_CMD;
               rsp_value_in = CMD_SET_LEDS;
               rsp_last_in  = 1'b0;
            end
            2'b11: begin
               rsp_kind_in  = KIND_CMD;
               rsp_value_in = s1_leds_ff;
               rsp_last_in  = 1'b1;
            end
            default: begin
               rsp_kind_in  = KIND_CHAR;
               rsp_value_in = map_rd_data;
               rsp_last_in  = 1'b1;
            end
         endcase
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_held_ff <= 1'b0;
         caps_on_ff    <= 1'b0;
         num_on_ff     <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s1_second_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         shift_held_ff <= shift_held_in;
         caps_on_ff    <= caps_on_in;
         num_on_ff     <= num_on_in;
         s1_valid_ff   <= s1_valid_in;
         s1_second_ff  <= s1_second_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      s1_led_ff    <= s1_led_in;
      s1_leds_ff   <= s1_leds_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // checks
   `KST_ASSERT_NEXT(a_lock_enters_stage, req_fire && is_lock, s1_valid_ff && s1_led_ff,
      "lock code did not enter the lookup stage")
   `KST_ASSERT_NOW(a_second_only_led, s1_second_ff, s1_valid_ff && s1_led_ff,
      "second led byte pending without a led command")
   `KST_ASSERT_NOW(a_cmd_first_byte,
      rsp_valid_ff && (rsp_kind_ff == KIND_CMD) && !rsp_last_ff,
      rsp_value_ff == CMD_SET_LEDS, "first command byte is not set-leds")
   `KST_ASSERT_NOW(a_char_is_last, rsp_valid_ff && (rsp_kind_ff == KIND_CHAR), rsp_last_ff,
      "character transfer not marked last")
   `KST_ASSERT_NOW(a_led_scroll_on,
      rsp_valid_ff && (rsp_kind_ff == KIND_CMD) && rsp_last_ff,
      rsp_value_ff[0], "led value without scroll lock")

endmodule

`default_nettype wire

// ===== bench/tb_keyboard_scancode_translator_unit.sv =====
`timescale 1ns / 1ps

// testbench for keyboard_scancode_translator_unit: map writes, shift and lock tracking,
// led command pairs and character lookups, checked against an in-bench predictor
// depends on kst_pkg, kst_req_if, kst_rsp_if and the translator rtl

module tb_keyboard_scancode_translator_unit;
   import kst_pkg::*;

   localparam int MAP_ENTRIES  = MAP_ENTRIES_DEFAULT;
   localparam int TARGET_ITEMS = 1050;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 160;
   localparam int HOLD_SPACING = 450;
   localparam int TAIL_CYCLES  = 10;
   localparam int PRINT_LIMIT  = 60;

   typedef struct packed {
      logic                  op;
      logic [SCANCODE_W-1:0] scancode;
      logic [MAP_SEL_W-1:0]  map_select;
      logic [MAP_IDX_W-1:0]  map_index;
      logic [CHAR_W-1:0]     map_char;
   } key_req_type;

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] value;
      logic              last;
   } key_rsp_type;

   // packed so that the struct value is the map number: num*4 + caps*2 + shift
   typedef struct packed {
      logic num_on;
      logic caps_on;
      logic shift_held;
   } lock_flags_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kst_req_if req_if();
   kst_rsp_if rsp_if();

   keyboard_scancode_translator_unit #(
      .MAP_ENTRIES(MAP_ENTRIES)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   // predictor state, advanced on each accepted transfer
   logic [CHAR_W-1:0] key_maps [NUM_MAPS*MAP_ENTRIES];
   lock_flags_type    key_flags = '0;
   key_rsp_type       expected_keys[$];

   // stimulus planning state
   key_req_type    pending_keys[$];
   bit             map_written [NUM_MAPS*MAP_ENTRIES];
   lock_flags_type plan_flags    = '0;
   int             useful_items  = 0;
   int             planned_items = 0;

   int accepted_items = 0;
   int rsp_seen       = 0;
   int mismatch_count = 0;
   bit req_accepted   = 1'b0;

   // sender and receiver pacing
   int burst_left   = 0;
   int gap_left     = 0;
   int hold_left    = 0;
   int next_hold_at = 300;
   int ready_mode   = 0;
   int mode_left    = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int map_slot(logic [MAP_SEL_W-1:0] sel, logic [SCANCODE_W-1:0] idx);
      return int'(sel) * MAP_ENTRIES + int'(idx);
   endfunction

   function automatic bit is_lookup(logic [SCANCODE_W-1:0] code);
      return code < CODE_LIMIT && code != CODE_LSHIFT && code != CODE_RSHIFT &&
             code != CODE_CAPS && code != CODE_NUM;
   endfunction

   // flag update caused by one scancode
   function automatic lock_flags_type flags_after(lock_flags_type f,
                                                  logic [SCANCODE_W-1:0] code);
      lock_flags_type n;
      n = f;
      case (code)
         CODE_LSHIFT_UP, CODE_RSHIFT_UP: n.shift_held = 1'b0;
         CODE_LSHIFT, CODE_RSHIFT:       n.shift_held = 1'b1;
         CODE_CAPS:                      n.caps_on    = ~f.caps_on;
         CODE_NUM:                       n.num_on     = ~f.num_on;
         default: ;
      endcase
      return n;
   endfunction

   // expected results of one accepted request
   function automatic void predict_key(key_req_type k);
      logic [CHAR_W-1:0] led;
      if (k.op == OP_MAP_WRITE) begin
         if (k.map_index < MAP_ENTRIES)
            key_maps[map_slot(k.map_select, k.map_index)] = k.map_char;
      end else begin
         key_flags = flags_after(key_flags, k.scancode);
         if (k.scancode == CODE_CAPS || k.scancode == CODE_NUM) begin
            led = {5'b00000, key_flags.caps_on, key_flags.num_on, 1'b1};
            expected_keys.push_back(key_rsp_type'{KIND_CMD, CMD_SET_LEDS, 1'b0});
            expected_keys.push_back(key_rsp_type'{KIND_CMD, led, 1'b1});
         end else if (is_lookup(k.scancode)) begin
            expected_keys.push_back(key_rsp_type'{KIND_CHAR,
               key_maps[map_slot(key_flags, k.scancode)], 1'b1});
         end
      end
   endfunction

   function automatic void plan_write(logic [MAP_SEL_W-1:0] sel, logic [MAP_IDX_W-1:0] idx,
                                      logic [CHAR_W-1:0] ch);
      key_req_type k;
      k.op         = OP_MAP_WRITE;
      k.scancode   = SCANCODE_W'($urandom);
      k.map_select = sel;
      k.map_index  = idx;
      k.map_char   = ch;
      pending_keys.push_back(k);
      if (idx < MAP_ENTRIES)
         map_written[map_slot(sel, idx)] = 1'b1;
      useful_items++;
   endfunction

   // a lookup of an entry never written is preceded by a write of that entry
   function automatic void plan_code(logic [SCANCODE_W-1:0] code);
      key_req_type k;
      if (is_lookup(code) && !map_written[map_slot(plan_flags, code)])
         plan_write(plan_flags, code[MAP_IDX_W-1:0], CHAR_W'($urandom));
      k.op         = OP_TRANSLATE;
      k.scancode   = code;
      k.map_select = MAP_SEL_W'($urandom);
      k.map_index  = MAP_IDX_W'($urandom);
      k.map_char   = CHAR_W'($urandom);
      pending_keys.push_back(k);
      plan_flags = flags_after(plan_flags, code);
      if (code < CODE_LIMIT || code == CODE_LSHIFT_UP || code == CODE_RSHIFT_UP)
         useful_items++;
   endfunction

   function automatic void plan_random();
      int pick;
      int run_len;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         plan_code(SCANCODE_W'($urandom_range(0, CODE_LIMIT - 1)));
      end else if (pick < 60) begin
         // shifted run: make, a few keys, break
         plan_code($urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT);
         run_len = $urandom_range(1, 5);
         repeat (run_len) plan_code(SCANCODE_W'($urandom_range(0, CODE_LIMIT - 1)));
         plan_code($urandom_range(0, 1) ? CODE_LSHIFT_UP : CODE_RSHIFT_UP);
      end else if (pick < 70) begin
         plan_code($urandom_range(0, 1) ? CODE_CAPS : CODE_NUM);
      end else if (pick < 85) begin
         plan_write(MAP_SEL_W'($urandom), MAP_IDX_W'($urandom), CHAR_W'($urandom));
      end else begin
         // any byte, mostly ignored codes
         plan_code(SCANCODE_W'($urandom));
      end
   endfunction

   task automatic flag_mismatch(string field, int got, int want);
      if (mismatch_count < PRINT_LIMIT)
         $display("result %0d: %s got %0h expected %0h", rsp_seen, field, got, want);
      mismatch_count++;
   endtask

   // request driver: bursts and gaps, no gaps while the receiver holds off
   always @(negedge clock) begin : drive_req
      key_req_type k;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_accepted) begin
         if (gap_left > 0 && hold_left == 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_keys.size() != 0) begin
            k = pending_keys.pop_front();
            req_if.op         <= k.op;
            req_if.scancode   <= k.scancode;
            req_if.map_select <= k.map_select;
            req_if.map_index  <= k.map_index;
            req_if.map_char   <= k.map_char;
            req_if.valid      <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left   = $urandom_range(0, 3) != 0 ? $urandom_range(1, 8) : 0;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result ready: random modes, plus a long hold-off every few hundred transfers
   always @(negedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (accepted_items >= next_hold_at) begin
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + HOLD_SPACING;
         rsp_if.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            default: rsp_if.ready <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   // result check first, then prediction for the request taken at this edge
   always @(posedge clock) begin : watch_ports
      key_rsp_type want;
      key_req_type taken;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_keys.size() == 0) begin
               flag_mismatch("unexpected transfer, value", rsp_if.value, 0);
            end else begin
               want = expected_keys.pop_front();
               if (rsp_if.kind !== want.kind)
                  flag_mismatch("kind", rsp_if.kind, want.kind);
               if (rsp_if.value !== want.value)
                  flag_mismatch("value", rsp_if.value, want.value);
               if (rsp_if.last !== want.last)
                  flag_mismatch("last", rsp_if.last, want.last);
            end
            rsp_seen++;
         end
         if (req_if.valid && req_if.ready) begin
            taken = {req_if.op, req_if.scancode, req_if.map_select, req_if.map_index,
                     req_if.map_char};
            predict_key(taken);
            accepted_items <= accepted_items + 1;
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin : watchdog
      int idle_run;
      idle_run = 0;
      while (idle_run < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("keyboard_scancode_translator_unit verification failed");
      $finish;
   end

   initial begin : run_test
      req_if.valid      = 1'b0;
      req_if.op         = OP_TRANSLATE;
      req_if.scancode   = '0;
      req_if.map_select = '0;
      req_if.map_index  = '0;
      req_if.map_char   = '0;
      rsp_if.ready      = 1'b0;

      // directed: extreme map entries, every special code, ignored codes
      plan_write(3'd0, 7'd0, 8'h00);
      plan_write(3'd7, 7'd127, 8'hFF);
      plan_code(8'h00);
      plan_code(SCANCODE_W'(CODE_LIMIT - 1));
      plan_code(CODE_LSHIFT);
      plan_code(8'h1E);
      plan_code(CODE_LSHIFT_UP);
      plan_code(CODE_RSHIFT);
      plan_code(CODE_CAPS);
      plan_code(CODE_NUM);
      plan_code(8'h10);
      plan_code(CODE_RSHIFT_UP);
      plan_code(CODE_CAPS);
      plan_code(8'h10);
      plan_code(CODE_LIMIT);
      plan_code(8'h80);
      plan_code(8'hFF);
      plan_code(CODE_NUM);
      plan_code(SCANCODE_W'(CODE_LIMIT - 1));

      while (useful_items < TARGET_ITEMS) plan_random();
      planned_items = pending_keys.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_items < planned_items) @(posedge clock);
      while (expected_keys.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("keyboard_scancode_translator_unit verification clean");
      else
         $display("keyboard_scancode_translator_unit verification failed");
      $finish;
   end

endmodule

// ===== keyboard_scancode_translator_unit.f =====
+incdir+rtl/core
rtl/core/kst_pkg.sv
rtl/core/kst_req_if.sv
rtl/core/kst_rsp_if.sv
rtl/core/kst_ram.sv
rtl/core/keyboard_scancode_translator_unit.sv
bench/tb_keyboard_scancode_translator_unit.sv
